>>> rtl/crcse_pkg.sv
// ----------------------------------------------------------------------------
// crcse_pkg
// Shared types and constants of the CRC-8 / CRC-16 byte stream engine.
// ----------------------------------------------------------------------------
package crcse_pkg;

  typedef enum logic {
    CRC_MODE_16 = 1'b0,
    CRC_MODE_8  = 1'b1
  } crc_mode_t;

  localparam logic [15:0] POLY16   = 16'h8005;
  localparam logic [7:0]  POLY8    = 8'h31;
  localparam logic [15:0] INIT16   = 16'hFFFF;
  localparam logic [7:0]  INIT8    = 8'hFF;
  localparam logic [15:0] XOROUT16 = 16'hFFFF;
  localparam logic [7:0]  XOROUT8  = 8'hFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } msg_beat_t;

endpackage

>>> rtl/crcse_msg_if.sv
// ----------------------------------------------------------------------------
// crcse_msg_if
// Message byte channel: valid/ready handshake with byte and framing flags.
// ----------------------------------------------------------------------------
interface crcse_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output first_byte,
                  output last_byte, input ready);
  modport sink   (input valid, input data_byte, input first_byte,
                  input last_byte, output ready);
endinterface

>>> rtl/crcse_crc_if.sv
// ----------------------------------------------------------------------------
// crcse_crc_if
// Checksum result channel: valid/ready handshake with a 16-bit checksum.
// ----------------------------------------------------------------------------
interface crcse_crc_if;
  logic        valid;
  logic        ready;
  logic [15:0] crc_value;

  modport source (output valid, output crc_value, input ready);
  modport sink   (input valid, input crc_value, output ready);
endinterface

>>> rtl/crcse_fold.sv
// ----------------------------------------------------------------------------
// crcse_fold
// Folds one byte into the running remainder, MSB first, in either mode, and
// forms the final checksum after the output XOR.
// ----------------------------------------------------------------------------
module crcse_fold import crcse_pkg::*; (
  input  crc_mode_t   crc_mode,
  input  logic        first_byte,
  input  logic [15:0] remainder,
  input  logic [7:0]  data_byte,
  output logic [15:0] remainder_next,
  output logic [15:0] crc_value
);

  logic [15:0] r16;
  logic [7:0]  r8;

  always_comb begin
    r16 = (first_byte ? INIT16 : remainder) ^ {data_byte, 8'h00};
    r8  = (first_byte ? INIT8 : remainder[7:0]) ^ data_byte;
    for (int k = 0; k < 8; k++) begin
      r16 = r16[15] ? ({r16[14:0], 1'b0} ^ POLY16) : {r16[14:0], 1'b0};
      r8  = r8[7] ? ({r8[6:0], 1'b0} ^ POLY8) : {r8[6:0], 1'b0};
    end
    unique case (crc_mode)
      CRC_MODE_16: begin
        remainder_next = r16;
        crc_value      = r16 ^ XOROUT16;
      end
      CRC_MODE_8: begin
        // The upper byte is kept at zero in CRC-8 mode.
        remainder_next = {8'h00, r8};
        crc_value      = {8'h00, r8 ^ XOROUT8};
      end
      default: begin
        remainder_next = r16;
        crc_value      = r16 ^ XOROUT16;
      end
    endcase
  end

endmodule

>>> rtl/crc8_crc16_stream_engine.sv
// ----------------------------------------------------------------------------
// crc8_crc16_stream_engine
// Byte stream CRC engine, CRC-16 (poly 0x8005) or CRC-8 (poly 0x31).
// ----------------------------------------------------------------------------
// Result path: an accepted last beat moves from the input register into the
// result register; it waits in the input register while a previous result
// is still waiting for ready, and only then does the input stall.
// Throughput: otherwise one beat per cycle; the remainder update is a
// combinational XOR network between the input and remainder registers.
// Reset: remainder 0xFFFF, CRC-16 mode, both registers empty.
module crc8_crc16_stream_engine import crcse_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_wdata,
  crcse_msg_if.sink    msg,
  crcse_crc_if.source  crc
);

  crc_mode_t   crc_mode;
  logic [15:0] remainder;
  logic [15:0] remainder_next;
  logic [15:0] fold_crc;
  logic        s1_valid;
  msg_beat_t   s1;
  logic        s1_go;
  logic        out_valid;
  logic [15:0] out_crc;

  // A last beat moves on only when the result register can take it.
  assign s1_go     = s1_valid && (!s1.last_byte || !out_valid || crc.ready);
  assign msg.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_mode <= CRC_MODE_16;
    end else if (cfg_we) begin
      crc_mode <= crc_mode_t'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (msg.ready) begin
      s1_valid <= msg.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (msg.ready && msg.valid) begin
      s1.data_byte  <= msg.data_byte;
      s1.first_byte <= msg.first_byte;
      s1.last_byte  <= msg.last_byte;
    end
  end

  crcse_fold u_fold (
    .crc_mode       (crc_mode),
    .first_byte     (s1.first_byte),
    .remainder      (remainder),
    .data_byte      (s1.data_byte),
    .remainder_next (remainder_next),
    .crc_value      (fold_crc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      remainder <= INIT16;
    end else if (s1_go) begin
      remainder <= remainder_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1.last_byte) begin
      out_valid <= 1'b1;
    end else if (crc.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1.last_byte) begin
      out_crc <= fold_crc;
    end
  end

  assign crc.valid     = out_valid;
  assign crc.crc_value = out_crc;

  a_last_waits: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1.last_byte && out_valid && !crc.ready) |=> s1_valid)
    else $error("last beat left the input register while the result was stalled");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1.last_byte) |=> out_valid)
    else $error("finished checksum not presented");

  a_crc8_upper_zero: assert property (@(posedge clk) disable iff (rst)
    (s1_go && crc_mode == CRC_MODE_8) |=> (remainder[15:8] == 8'h00))
    else $error("CRC-8 update left upper remainder bits set");

  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> msg.ready)
    else $error("input refused while the input register is empty");

endmodule
